>>> rtl/assert_macros.svh
// assertion macros shared by the compensation datapath
// no dependencies; included by esc_div and esc_press_post
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ESC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define ESC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/esc_pkg.sv
// types, constants and helpers of the sensor compensation datapath
// no dependencies; used by every module under rtl
package esc_pkg;

  localparam int TempStages = 5;
  localparam int HumStages  = 9;
  localparam int PreStages  = 6;
  localparam int DivBits    = 64;
  localparam int PostStages = 6;

  localparam logic [2:0] RegCalibTemp   = 3'd0;
  localparam logic [2:0] RegCalibPressA = 3'd1;
  localparam logic [2:0] RegCalibPressB = 3'd2;
  localparam logic [2:0] RegCalibPressC = 3'd3;
  localparam logic [2:0] RegCalibHumA   = 3'd4;
  localparam logic [2:0] RegCalibHumB   = 3'd5;

  localparam logic [16:0] HumMax   = 17'd102400;
  localparam logic [31:0] HumLimit = 32'd419430400;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic [31:0]        press_q24_8;
    logic [16:0]        hum_q22_10;
    logic               press_invalid;
  } out_t;

  // calibration words, already extended for the datapath
  typedef struct packed {
    logic signed [31:0] t1;
    logic signed [31:0] t2;
    logic signed [31:0] t3;
    logic signed [16:0] p1;
    logic signed [16:0] p2;
    logic signed [16:0] p3;
    logic signed [16:0] p4;
    logic signed [16:0] p5;
    logic signed [16:0] p6;
    logic signed [16:0] p7;
    logic signed [16:0] p8;
    logic signed [16:0] p9;
    logic signed [31:0] h1;
    logic signed [31:0] h2;
    logic signed [31:0] h3;
    logic signed [31:0] h4;
    logic signed [31:0] h5;
    logic signed [31:0] h6;
  } cal_t;

  typedef struct packed {
    logic signed [31:0] fine;
    logic signed [31:0] temp;
    logic [19:0]        raw_press;
    logic [15:0]        raw_hum;
  } tf_t;

  typedef struct packed {
    logic signed [31:0] fine;
    logic signed [31:0] temp;
    logic [19:0]        raw_press;
    logic [16:0]        hum;
  } hm_t;

  typedef struct packed {
    logic signed [31:0] temp;
    logic [16:0]        hum;
    logic               inv;
  } side_t;

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
    side_t       side;
  } pp_t;

  typedef struct packed {
    logic [63:0] quot;
    side_t       side;
  } dv_t;

  // a * b modulo 2^64, split into two narrow partial products
  function automatic logic [63:0] mulw(input logic [63:0] a, input logic signed [16:0] b);
    logic signed [49:0] lo;
    logic signed [48:0] hi;
    lo = $signed({1'b0, a[31:0]}) * b;
    hi = $signed(a[63:32]) * b;
    mulw = {{14{lo[49]}}, lo} + {hi[31:0], 32'b0};
  endfunction

endpackage

>>> rtl/esc_temp.sv
// temperature stages: fine value and temperature in hundredths
// depends on esc_pkg
module esc_temp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  esc_pkg::in_t  sample_i,
  input  esc_pkg::cal_t cal_i,
  output logic          valid_o,
  output esc_pkg::tf_t  tf_o
);

  localparam int Stg = esc_pkg::TempStages;

  logic [Stg-1:0]     vld_q;
  esc_pkg::in_t       raw_q [Stg];
  logic signed [31:0] a1_q, d_q, am_q, dd_q, a_q, bm_q, fine4_q, fine_q, temp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Stg-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q[0] <= sample_i;
    for (int k = 1; k < Stg; k++) begin
      raw_q[k] <= raw_q[k-1];
    end
    a1_q    <= $signed({15'b0, sample_i.raw_temp[19:3]}) - (cal_i.t1 <<< 1);
    d_q     <= $signed({16'b0, sample_i.raw_temp[19:4]}) - cal_i.t1;
    am_q    <= a1_q * cal_i.t2;
    dd_q    <= d_q * d_q;
    a_q     <= am_q >>> 11;
    bm_q    <= (dd_q >>> 12) * cal_i.t3;
    fine4_q <= a_q + (bm_q >>> 14);
    fine_q  <= fine4_q;
    temp_q  <= (fine4_q * 32'sd5 + 32'sd128) >>> 8;
  end

  assign valid_o        = vld_q[Stg-1];
  assign tf_o.fine      = fine_q;
  assign tf_o.temp      = temp_q;
  assign tf_o.raw_press = raw_q[Stg-1].raw_press;
  assign tf_o.raw_hum   = raw_q[Stg-1].raw_hum;

endmodule

>>> rtl/esc_hum.sv
// humidity stages: 32-bit wrapping formula and clamp to 0..100 percent
// depends on esc_pkg
module esc_hum (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  esc_pkg::tf_t  tf_i,
  input  esc_pkg::cal_t cal_i,
  output logic          valid_o,
  output esc_pkg::hm_t  hm_o
);

  localparam int Stg = esc_pkg::HumStages;

  logic [Stg-1:0]     vld_q;
  esc_pkg::tf_t       car_q [Stg];
  logic signed [31:0] hv_q, u_q, u2_q, m5_q, m6_q, m3_q, a3_q, c1_q, c2_q;
  logic signed [31:0] a4_q, b_q, a5_q, bm_q, hv2_q, hv7_q, s_q, hv8_q, t_q;
  logic [16:0]        hum_q;
  logic signed [31:0] hv3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Stg-2:0], valid_i};
    end
  end

  assign hv3 = hv8_q - (t_q >>> 4);

  always_ff @(posedge clk_i) begin
    car_q[0] <= tf_i;
    for (int k = 1; k < Stg; k++) begin
      car_q[k] <= car_q[k-1];
    end
    hv_q  <= tf_i.fine - 32'sd76800;
    u_q   <= $signed({2'b0, tf_i.raw_hum, 14'b0}) - (cal_i.h4 <<< 20);
    m5_q  <= cal_i.h5 * hv_q;
    m6_q  <= hv_q * cal_i.h6;
    m3_q  <= hv_q * cal_i.h3;
    u2_q  <= u_q;
    a3_q  <= (u2_q - m5_q + 32'sd16384) >>> 15;
    c1_q  <= m6_q >>> 10;
    c2_q  <= (m3_q >>> 11) + 32'sd32768;
    b_q   <= c1_q * c2_q;
    a4_q  <= a3_q;
    bm_q  <= ((b_q >>> 10) + 32'sd2097152) * cal_i.h2;
    a5_q  <= a4_q;
    hv2_q <= a5_q * ((bm_q + 32'sd8192) >>> 14);
    s_q   <= (hv2_q >>> 15) * (hv2_q >>> 15);
    hv7_q <= hv2_q;
    t_q   <= (s_q >>> 7) * cal_i.h1;
    hv8_q <= hv7_q;
    // negative gives zero, above full scale gives full scale
    if (hv3[31]) begin
      hum_q <= '0;
    end else if (hv3 > $signed(esc_pkg::HumLimit)) begin
      hum_q <= esc_pkg::HumMax;
    end else begin
      hum_q <= hv3[28:12];
    end
  end

  assign valid_o        = vld_q[Stg-1];
  assign hm_o.fine      = car_q[Stg-1].fine;
  assign hm_o.temp      = car_q[Stg-1].temp;
  assign hm_o.raw_press = car_q[Stg-1].raw_press;
  assign hm_o.hum       = hum_q;

endmodule

>>> rtl/esc_press_pre.sv
// pressure stages before the divide: divisor and scaled numerator
// depends on esc_pkg
module esc_press_pre (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  esc_pkg::hm_t  hm_i,
  input  esc_pkg::cal_t cal_i,
  output logic          valid_o,
  output esc_pkg::pp_t  pp_o
);

  localparam int Stg = esc_pkg::PreStages;

  logic [Stg-1:0]     vld_q;
  esc_pkg::hm_t       car_q [Stg];
  logic signed [34:0] x1_q;
  logic signed [69:0] sq_full;
  logic [63:0]        sq_q, x2a_q, x1a_q, x2b_q, x1b_q, x2_q, x1n_q, y_q, num0_q;
  logic signed [51:0] m5_q, m2_q;
  logic [63:0]        num_q, den_q, den_d;
  logic [20:0]        pr;
  logic               inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Stg-2:0], valid_i};
    end
  end

  assign sq_full = x1_q * x1_q;
  assign pr      = 21'd1048576 - {1'b0, car_q[Stg-3].raw_press};
  assign den_d   = $signed(y_q) >>> 33;

  always_ff @(posedge clk_i) begin
    car_q[0] <= hm_i;
    for (int k = 1; k < Stg; k++) begin
      car_q[k] <= car_q[k-1];
    end
    x1_q   <= {{3{hm_i.fine[31]}}, hm_i.fine} - 35'sd128000;
    sq_q   <= sq_full[63:0];
    m5_q   <= x1_q * cal_i.p5;
    m2_q   <= x1_q * cal_i.p2;
    x2a_q  <= esc_pkg::mulw(sq_q, cal_i.p6);
    x1a_q  <= esc_pkg::mulw(sq_q, cal_i.p3);
    x2b_q  <= {{12{m5_q[51]}}, m5_q} << 17;
    x1b_q  <= {{12{m2_q[51]}}, m2_q} << 12;
    x2_q   <= x2a_q + x2b_q + ({{47{cal_i.p4[16]}}, cal_i.p4} << 35);
    x1n_q  <= $unsigned($signed(x1a_q) >>> 8) + x1b_q;
    y_q    <= esc_pkg::mulw(64'h0000_8000_0000_0000 + x1n_q, cal_i.p1);
    num0_q <= ({43'b0, pr} << 31) - x2_q;
    den_q  <= den_d;
    inv_q  <= (den_d == '0);
    num_q  <= esc_pkg::mulw(num0_q, 17'sd3125);
  end

  assign valid_o        = vld_q[Stg-1];
  assign pp_o.num       = num_q;
  assign pp_o.den       = den_q;
  assign pp_o.side.temp = car_q[Stg-1].temp;
  assign pp_o.side.hum  = car_q[Stg-1].hum;
  assign pp_o.side.inv  = inv_q;

endmodule

>>> rtl/esc_div.sv
// pipelined signed 64-bit divider, one quotient bit per stage
// depends on esc_pkg and assert_macros.svh
`include "assert_macros.svh"
module esc_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  esc_pkg::pp_t pp_i,
  output logic         valid_o,
  output esc_pkg::dv_t dv_o
);

  localparam int N = esc_pkg::DivBits;

  logic [N:0]       vld_q;
  logic [N-1:0]     rem_q [N+1];
  logic [N-1:0]     dvd_q [N+1];
  logic [N-1:0]     dsr_q [N+1];
  logic             neg_q [N+1];
  esc_pkg::side_t   side_q [N+1];
  logic [N-1:0]     rem_d [N+1];
  logic [N-1:0]     dvd_d [N+1];
  logic [N:0]       trial;
  logic             vo_q;
  esc_pkg::dv_t     dv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      vo_q  <= 1'b0;
    end else begin
      vld_q <= {vld_q[N-1:0], valid_i};
      vo_q  <= vld_q[N];
    end
  end

  always_comb begin
    rem_d[0] = '0;
    dvd_d[0] = '0;
    trial    = '0;
    for (int k = 0; k < N; k++) begin
      trial = {rem_q[k], dvd_q[k][N-1]};
      if (trial >= {1'b0, dsr_q[k]}) begin
        rem_d[k+1] = trial[N-1:0] - dsr_q[k];
        dvd_d[k+1] = {dvd_q[k][N-2:0], 1'b1};
      end else begin
        rem_d[k+1] = trial[N-1:0];
        dvd_d[k+1] = {dvd_q[k][N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // magnitudes in, sign applied at the end
    rem_q[0]  <= '0;
    dvd_q[0]  <= pp_i.num[N-1] ? (~pp_i.num + 1'b1) : pp_i.num;
    dsr_q[0]  <= pp_i.den[N-1] ? (~pp_i.den + 1'b1) : pp_i.den;
    neg_q[0]  <= pp_i.num[N-1] ^ pp_i.den[N-1];
    side_q[0] <= pp_i.side;
    for (int k = 1; k <= N; k++) begin
      rem_q[k]  <= rem_d[k];
      dvd_q[k]  <= dvd_d[k];
      dsr_q[k]  <= dsr_q[k-1];
      neg_q[k]  <= neg_q[k-1];
      side_q[k] <= side_q[k-1];
    end
    dv_q.quot <= neg_q[N] ? (~dvd_q[N] + 1'b1) : dvd_q[N];
    dv_q.side <= side_q[N];
  end

  assign valid_o = vo_q;
  assign dv_o    = dv_q;

  `ESC_ASSERT(a_div_rem_below_divisor, clk_i, rst_ni,
    (vld_q[N] && dsr_q[N] != '0) |-> (rem_q[N] < dsr_q[N]), "divider remainder not below divisor")

endmodule

>>> rtl/esc_press_post.sv
// pressure stages after the divide: correction terms and Q24.8 result
// depends on esc_pkg and assert_macros.svh
`include "assert_macros.svh"
module esc_press_post (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  esc_pkg::dv_t  dv_i,
  input  esc_pkg::cal_t cal_i,
  output logic          valid_o,
  output esc_pkg::out_t res_o
);

  localparam int Stg = esc_pkg::PostStages;

  logic [Stg-1:0]  vld_q;
  esc_pkg::side_t  side_q [Stg];
  logic [63:0]     p1_q, p2_q, p3_q, p4_q, p5_q;
  logic [63:0]     s13_q, s13b_q, m8_q, m8b_q, m8c_q, k_q, pl_q, x1_q, x2_q, sum_q;
  logic [31:0]     pc1_q, pc2_q;
  logic [63:0]     pres;
  esc_pkg::out_t   res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Stg-2:0], valid_i};
    end
  end

  assign pres = $unsigned($signed(sum_q) >>> 8) + ({{47{cal_i.p7[16]}}, cal_i.p7} << 4);

  always_ff @(posedge clk_i) begin
    side_q[0] <= dv_i.side;
    for (int k = 1; k < Stg; k++) begin
      side_q[k] <= side_q[k-1];
    end
    p1_q   <= dv_i.quot;
    s13_q  <= $signed(dv_i.quot) >>> 13;
    m8_q   <= esc_pkg::mulw(dv_i.quot, cal_i.p8);
    p2_q   <= p1_q;
    k_q    <= esc_pkg::mulw(s13_q, cal_i.p9);
    s13b_q <= s13_q;
    m8b_q  <= m8_q;
    // 64 by 64 wrapping product from 32-bit partial products
    pl_q   <= k_q[31:0] * s13b_q[31:0];
    pc1_q  <= k_q[31:0] * s13b_q[63:32];
    pc2_q  <= k_q[63:32] * s13b_q[31:0];
    p3_q   <= p2_q;
    m8c_q  <= m8b_q;
    x1_q   <= pl_q + {pc1_q + pc2_q, 32'b0};
    x2_q   <= $signed(m8c_q) >>> 19;
    p4_q   <= p3_q;
    sum_q  <= p4_q + $unsigned($signed(x1_q) >>> 25) + x2_q;
    p5_q   <= p4_q;
    res_q.temp_centi    <= side_q[Stg-2].temp;
    res_q.hum_q22_10    <= side_q[Stg-2].hum;
    res_q.press_invalid <= side_q[Stg-2].inv;
    res_q.press_q24_8   <= side_q[Stg-2].inv ? 32'd0 : pres[31:0];
  end

  assign valid_o = vld_q[Stg-1];
  assign res_o   = res_q;

  `ESC_ASSERT(a_post_quot_carried, clk_i, rst_ni,
    vld_q[Stg-2] |-> (p5_q == $past(p1_q, 4)), "quotient lost its alignment in post stages")

endmodule

>>> rtl/env_sensor_compensation.sv
// top level of the environmental sensor compensation datapath
// depends on esc_pkg, assert_macros.svh and the esc_* stage modules
//
// usage
//   sample beat: drive sample_i and raise start; it is taken at any edge where
//   start is high and busy is low. busy stays low, so one raw triple can be
//   taken on every clock cycle.
//   result beat: result_o is shown for exactly one cycle with result_valid_o
//   high, in input order, after passing every stage listed below.
//   the receiver cannot hold results off and none is needed: the pipeline
//   never stalls, each stage moves every cycle with a valid bit beside it.
//   calibration beat: cfg_valid_i with cfg_index_i / cfg_data_i, cfg_ready_o
//   always high; index 0 temp, 1..3 pressure, 4..5 humidity words; other
//   indexes are dropped. write only while no sample is in flight.
//   stages: 5 temperature + 9 humidity + 6 pressure setup
//   + 66 divider (one quotient bit per inner stage) + 6 pressure finish
//   throughput: one triple per cycle
//   reset: asynchronous, clears calibration words to zero and empties the
//   pipeline; no sweep is needed afterwards
module env_sensor_compensation (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  esc_pkg::in_t  sample_i,
  output logic          result_valid_o,
  output esc_pkg::out_t result_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [63:0]   cfg_data_i
);

  // calibration registers
  logic [47:0] calib_temp_q;
  logic [63:0] calib_press_a_q;
  logic [63:0] calib_press_b_q;
  logic [15:0] calib_press_c_q;
  logic [39:0] calib_hum_a_q;
  logic [31:0] calib_hum_b_q;

  esc_pkg::cal_t cal;
  esc_pkg::tf_t  tf;
  esc_pkg::hm_t  hm;
  esc_pkg::pp_t  pp;
  esc_pkg::dv_t  dv;
  logic          accept, tf_vld, hm_vld, pp_vld, dv_vld;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_temp_q    <= '0;
      calib_press_a_q <= '0;
      calib_press_b_q <= '0;
      calib_press_c_q <= '0;
      calib_hum_a_q   <= '0;
      calib_hum_b_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        esc_pkg::RegCalibTemp:   calib_temp_q    <= cfg_data_i[47:0];
        esc_pkg::RegCalibPressA: calib_press_a_q <= cfg_data_i;
        esc_pkg::RegCalibPressB: calib_press_b_q <= cfg_data_i;
        esc_pkg::RegCalibPressC: calib_press_c_q <= cfg_data_i[15:0];
        esc_pkg::RegCalibHumA:   calib_hum_a_q   <= cfg_data_i[39:0];
        esc_pkg::RegCalibHumB:   calib_hum_b_q   <= cfg_data_i[31:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // field split and extension of the calibration words
  always_comb begin
    cal.t1 = $signed({16'b0, calib_temp_q[15:0]});
    cal.t2 = $signed({{16{calib_temp_q[31]}}, calib_temp_q[31:16]});
    cal.t3 = $signed({{16{calib_temp_q[47]}}, calib_temp_q[47:32]});
    cal.p1 = $signed({1'b0, calib_press_a_q[15:0]});
    cal.p2 = $signed({calib_press_a_q[31], calib_press_a_q[31:16]});
    cal.p3 = $signed({calib_press_a_q[47], calib_press_a_q[47:32]});
    cal.p4 = $signed({calib_press_a_q[63], calib_press_a_q[63:48]});
    cal.p5 = $signed({calib_press_b_q[15], calib_press_b_q[15:0]});
    cal.p6 = $signed({calib_press_b_q[31], calib_press_b_q[31:16]});
    cal.p7 = $signed({calib_press_b_q[47], calib_press_b_q[47:32]});
    cal.p8 = $signed({calib_press_b_q[63], calib_press_b_q[63:48]});
    cal.p9 = $signed({calib_press_c_q[15], calib_press_c_q});
    cal.h1 = $signed({24'b0, calib_hum_a_q[7:0]});
    cal.h2 = $signed({{16{calib_hum_a_q[23]}}, calib_hum_a_q[23:8]});
    cal.h3 = $signed({24'b0, calib_hum_a_q[31:24]});
    cal.h6 = $signed({{24{calib_hum_a_q[39]}}, calib_hum_a_q[39:32]});
    cal.h4 = $signed({{16{calib_hum_b_q[15]}}, calib_hum_b_q[15:0]});
    cal.h5 = $signed({{16{calib_hum_b_q[31]}}, calib_hum_b_q[31:16]});
  end

  // temperature first: fine value feeds everything after it
  esc_temp u_temp (
    .clk_i, .rst_ni, .valid_i(accept), .sample_i, .cal_i(cal),
    .valid_o(tf_vld), .tf_o(tf)
  );

  esc_hum u_hum (
    .clk_i, .rst_ni, .valid_i(tf_vld), .tf_i(tf), .cal_i(cal),
    .valid_o(hm_vld), .hm_o(hm)
  );

  // pressure divisor and numerator, then the long divide
  esc_press_pre u_pre (
    .clk_i, .rst_ni, .valid_i(hm_vld), .hm_i(hm), .cal_i(cal),
    .valid_o(pp_vld), .pp_o(pp)
  );

  esc_div u_div (
    .clk_i, .rst_ni, .valid_i(pp_vld), .pp_i(pp),
    .valid_o(dv_vld), .dv_o(dv)
  );

  // finish pressure; its output register is the result register
  esc_press_post u_post (
    .clk_i, .rst_ni, .valid_i(dv_vld), .dv_i(dv), .cal_i(cal),
    .valid_o(result_valid_o), .res_o(result_o)
  );

  `ESC_ASSERT(a_invalid_forces_zero, clk_i, rst_ni,
    (result_valid_o && result_o.press_invalid) |-> (result_o.press_q24_8 == '0),
    "flagged pressure beat is not zero")
  `ESC_ASSERT_ALWAYS(a_hum_in_range, clk_i,
    result_valid_o |-> (result_o.hum_q22_10 <= esc_pkg::HumMax), "humidity above full scale")

endmodule
